FILE: src/jsc_pkg.sv
// Constants and types shared by the Julian-seconds to calendar-date converter.
package jsc_pkg;

    // Calendar selector codes.
    localparam logic [1:0] CAL_AUTO   = 2'd0;
    localparam logic [1:0] CAL_GREG   = 2'd1;
    localparam logic [1:0] CAL_JULIAN = 2'd2;

    // Number of register stages from the input beat to the result beat.
    localparam int NSTG = 11;

    // Supported input span and calendar switch point.
    localparam logic signed [39:0] SPAN_LOW    = -40'sd166876632000;
    localparam logic signed [39:0] SPAN_HIGH   = 40'sd275000000000;
    localparam logic signed [40:0] GREG_SWITCH = 41'sd198647467200;
    // Epoch shift plus one extra day, which keeps the rebased time positive.
    localparam logic signed [40:0] EPOCH_BIAS  = 41'sd166876718400;

    // Reciprocal multipliers; each quotient estimate is low by at most one.
    localparam logic [30:0] RCP_675    = 31'd1628906115; // 2^40 / 675
    localparam logic [7:0]  RCP_146097 = 8'd229;         // 2^25 / 146097
    localparam logic [20:0] RCP_7      = 21'd1198372;    // 2^23 / 7
    localparam logic [5:0]  RCP_3600   = 6'd36;          // 2^17 / 3600
    localparam logic [6:0]  RCP_60     = 7'd68;          // 2^12 / 60
    localparam logic [14:0] RCP_1461   = 15'd22966;      // 2^25 / 1461
    localparam logic [3:0]  RCP_153    = 4'd13;          // 2^11 / 153
    localparam logic [5:0]  RCP_5      = 6'd51;          // 2^8 / 5

    typedef struct packed {
        logic        out_of_span;
        logic        used_gregorian;
        logic [2:0]  weekday;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [14:0] year;
    } t_date;

endpackage

FILE: src/julian_seconds_to_calendar_date.sv
// Top level of the Julian-seconds to calendar-date converter pipeline.

// Converts a signed time in seconds from the Julian-day epoch noon, plus the
// time-zone offset register, into a proleptic Julian or Gregorian date with
// weekday and time of day. The pipeline takes one beat per clock while the
// output is not stalled; the depth is set by the chain of constant divisions
// (by 86400, 146097, 1461, 153, 5, 7, 3600 and 60), each done as a reciprocal
// multiply followed by one correction step. Stalls on the output fill empty
// stages first, so the input keeps accepting while results wait. The offset
// register is read by items in flight, so write it only while the pipeline is
// empty.
module julian_seconds_to_calendar_date import jsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data,     // zone_offset_seconds
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // julian_seconds
    input  logic [1:0]  s_axis_tuser,   // calendar_select
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // year_out[14:0], month_out[18:15], day_out[23:19], hour_out[28:24],
    // minute_out[34:29], second_out[40:35], weekday_out[43:41],
    // used_gregorian[44], out_of_span[45], zero pad[47:46]
    output logic [47:0] m_axis_tdata
);

    logic signed [16:0] r_zone_off;
    logic [NSTG-1:0]    r_vld;
    logic [NSTG-1:0]    en;

    // Stage 0: input capture.
    logic signed [39:0] r0_js;
    logic [1:0]         r0_sel;
    // Stage 1: rebased time.
    logic [38:0] r1_t;
    logic        r1_greg, r1_oos;
    // Stage 2: day estimate.
    logic [22:0] r2_q0;
    logic [31:0] r2_x;
    logic [6:0]  r2_lo;
    logic        r2_greg, r2_oos;
    // Stage 3: day count plus one and time of day.
    logic [22:0] r3_ep;
    logic [16:0] r3_tod;
    logic        r3_greg, r3_oos;
    // Stage 4: estimates for century, weekday and hour.
    logic [22:0] r4_ep;
    logic [24:0] r4_p1;
    logic [7:0]  r4_qg0;
    logic [22:0] r4_w;
    logic [20:0] r4_qw0;
    logic [16:0] r4_tod;
    logic [4:0]  r4_hr0;
    logic        r4_greg, r4_oos;
    // Stage 5
    logic [22:0] r5_ep;
    logic [7:0]  r5_qg;
    logic [2:0]  r5_wd;
    logic [4:0]  r5_hour;
    logic [11:0] r5_rtod;
    logic        r5_greg, r5_oos;
    // Stage 6
    logic [24:0] r6_ee;
    logic [5:0]  r6_mn0;
    logic [11:0] r6_rtod;
    logic [2:0]  r6_wd;
    logic [4:0]  r6_hour;
    logic        r6_greg, r6_oos;
    // Stage 7
    logic [24:0] r7_ee;
    logic [13:0] r7_yq0;
    logic [5:0]  r7_min, r7_sec;
    logic [2:0]  r7_wd;
    logic [4:0]  r7_hour;
    logic        r7_greg, r7_oos;
    // Stage 8
    logic [13:0] r8_yq;
    logic [8:0]  r8_g;
    logic [5:0]  r8_min, r8_sec;
    logic [2:0]  r8_wd;
    logic [4:0]  r8_hour;
    logic        r8_greg, r8_oos;
    // Stage 9
    logic [13:0] r9_yq;
    logic [3:0]  r9_hq;
    logic [7:0]  r9_hr;
    logic [5:0]  r9_min, r9_sec;
    logic [2:0]  r9_wd;
    logic [4:0]  r9_hour;
    logic        r9_greg, r9_oos;
    // Stage 10: result register.
    t_date r10_res;

    // A stage may load when it is empty or when the stage after it loads.
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {2'b00, r10_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_off <= '0;
            r_vld      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_zone_off <= i_cfg_data;
            end
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1 logic: offset, span check, calendar choice and rebase.
    logic signed [40:0] n1_local;
    logic signed [40:0] n1_t;
    logic               n1_greg;
    always_comb begin
        n1_local = 41'(r0_js) + 41'(r_zone_off);
        n1_t     = n1_local + EPOCH_BIAS;
        unique case (r0_sel)
            CAL_GREG:   n1_greg = 1'b1;
            CAL_JULIAN: n1_greg = 1'b0;
            default:    n1_greg = (n1_local >= GREG_SWITCH);
        endcase
    end

    // Stage 2 logic: divide by 86400 as a shift by 7 and a divide by 675.
    logic [62:0] n2_prod;
    assign n2_prod = 63'(r1_t[38:7]) * 63'(RCP_675);

    // Stage 3 logic: correct the day quotient.
    logic [31:0] n3_r;
    logic        n3_c;
    logic [31:0] n3_rr;
    always_comb begin
        n3_r  = r2_x - 32'(r2_q0) * 32'd675;
        n3_c  = (n3_r >= 32'd675);
        n3_rr = n3_c ? n3_r - 32'd675 : n3_r;
    end

    // Stage 4 logic; the day count is ep - 1.
    logic [24:0] n4_p1;
    logic [32:0] n4_pg;
    logic [22:0] n4_w;
    logic [43:0] n4_pw;
    logic [22:0] n4_ph;
    always_comb begin
        n4_p1 = {r3_ep, 2'b00} + 25'd145549;
        n4_pg = 33'(n4_p1) * 33'(RCP_146097);
        n4_w  = r3_ep + 23'd4;
        n4_pw = 44'(n4_w) * 44'(RCP_7);
        n4_ph = 23'(r3_tod) * 23'(RCP_3600);
    end

    // Stage 5 logic: corrections for century, weekday and hour.
    logic [24:0] n5_rg;
    logic [22:0] n5_rw;
    logic [16:0] n5_rh;
    logic        n5_ch;
    always_comb begin
        n5_rg = r4_p1 - 25'(r4_qg0) * 25'd146097;
        n5_rw = r4_w - 23'(r4_qw0) * 23'd7;
        n5_rh = r4_tod - 17'(r4_hr0) * 17'd3600;
        n5_ch = (n5_rh >= 17'd3600);
    end

    // Stage 6 logic: shifted day count for the four-year cycle and minute estimate.
    logic [9:0]  n6_a3;
    logic [22:0] n6_f;
    logic [17:0] n6_pm;
    always_comb begin
        n6_a3 = 10'(r5_qg) * 10'd3;
        n6_f  = r5_greg ? r5_ep + 23'd1323 + 23'(n6_a3[9:2]) : r5_ep + 23'd1400;
        n6_pm = 18'(r5_rtod) * 18'(RCP_60);
    end

    // Stage 7 logic
    logic [39:0] n7_py;
    logic [11:0] n7_rm;
    logic        n7_cm;
    always_comb begin
        n7_py = 40'(r6_ee) * 40'(RCP_1461);
        n7_rm = r6_rtod - 12'(r6_mn0) * 12'd60;
        n7_cm = (n7_rm >= 12'd60);
    end

    // Stage 8 logic
    logic [24:0] n8_ry;
    logic        n8_cy;
    logic [24:0] n8_ryc;
    always_comb begin
        n8_ry  = r7_ee - 25'(r7_yq0) * 25'd1461;
        n8_cy  = (n8_ry >= 25'd1461);
        n8_ryc = n8_cy ? n8_ry - 25'd1461 : n8_ry;
    end

    // Stage 9 logic: month index and day offset from the day of the year.
    logic [10:0] n9_h;
    logic [14:0] n9_pq;
    logic [10:0] n9_rh;
    logic        n9_c;
    always_comb begin
        n9_h  = 11'(r8_g) * 11'd5 + 11'd2;
        n9_pq = 15'(n9_h) * 15'(RCP_153);
        n9_rh = n9_h - 11'(n9_pq[14:11]) * 11'd153;
        n9_c  = (n9_rh >= 11'd153);
    end

    // Stage 10 logic: day, month, year and the out-of-span blanking.
    logic [15:0] n10_pd;
    logic [7:0]  n10_rd;
    logic [4:0]  n10_day;
    logic [3:0]  n10_mm;
    logic [3:0]  n10_month;
    logic [14:0] n10_year;
    t_date       n10_res;
    always_comb begin
        n10_pd    = 16'(r9_hr) * 16'(RCP_5);
        n10_rd    = r9_hr - 8'(n10_pd[12:8]) * 8'd5;
        n10_day   = n10_pd[12:8] + 5'(n10_rd >= 8'd5) + 5'd1;
        n10_mm    = r9_hq + 4'd2;
        n10_mm    = (n10_mm >= 4'd12) ? n10_mm - 4'd12 : n10_mm;
        n10_month = n10_mm + 4'd1;
        // January and February belong to the following year.
        n10_year  = 15'(r9_yq) - 15'd10004 + 15'(n10_month <= 4'd2);
        if (r9_oos) begin
            n10_res             = '0;
            n10_res.out_of_span = 1'b1;
        end else begin
            n10_res.out_of_span    = 1'b0;
            n10_res.used_gregorian = r9_greg;
            n10_res.weekday        = r9_wd;
            n10_res.second         = r9_sec;
            n10_res.minute         = r9_min;
            n10_res.hour           = r9_hour;
            n10_res.day            = n10_day;
            n10_res.month          = n10_month;
            n10_res.year           = n10_year;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_js  <= s_axis_tdata;
            r0_sel <= s_axis_tuser;
        end
        if (en[1]) begin
            r1_t    <= n1_t[38:0];
            r1_greg <= n1_greg;
            r1_oos  <= (r0_js < SPAN_LOW) || (r0_js > SPAN_HIGH);
        end
        if (en[2]) begin
            r2_q0   <= n2_prod[62:40];
            r2_x    <= r1_t[38:7];
            r2_lo   <= r1_t[6:0];
            r2_greg <= r1_greg;
            r2_oos  <= r1_oos;
        end
        if (en[3]) begin
            r3_ep   <= r2_q0 + 23'(n3_c);
            r3_tod  <= {n3_rr[9:0], r2_lo};
            r3_greg <= r2_greg;
            r3_oos  <= r2_oos;
        end
        if (en[4]) begin
            r4_ep   <= r3_ep;
            r4_p1   <= n4_p1;
            r4_qg0  <= n4_pg[32:25];
            r4_w    <= n4_w;
            r4_qw0  <= n4_pw[43:23];
            r4_tod  <= r3_tod;
            r4_hr0  <= n4_ph[21:17];
            r4_greg <= r3_greg;
            r4_oos  <= r3_oos;
        end
        if (en[5]) begin
            r5_ep   <= r4_ep;
            r5_qg   <= r4_qg0 + 8'(n5_rg >= 25'd146097);
            r5_wd   <= (n5_rw >= 23'd7) ? 3'(n5_rw - 23'd7) + 3'd1 : n5_rw[2:0] + 3'd1;
            r5_hour <= r4_hr0 + 5'(n5_ch);
            r5_rtod <= n5_ch ? 12'(n5_rh - 17'd3600) : n5_rh[11:0];
            r5_greg <= r4_greg;
            r5_oos  <= r4_oos;
        end
        if (en[6]) begin
            r6_ee   <= {n6_f, 2'b11};
            r6_mn0  <= n6_pm[17:12];
            r6_rtod <= r5_rtod;
            r6_wd   <= r5_wd;
            r6_hour <= r5_hour;
            r6_greg <= r5_greg;
            r6_oos  <= r5_oos;
        end
        if (en[7]) begin
            r7_ee   <= r6_ee;
            r7_yq0  <= n7_py[38:25];
            r7_min  <= r6_mn0 + 6'(n7_cm);
            r7_sec  <= n7_cm ? 6'(n7_rm - 12'd60) : n7_rm[5:0];
            r7_wd   <= r6_wd;
            r7_hour <= r6_hour;
            r7_greg <= r6_greg;
            r7_oos  <= r6_oos;
        end
        if (en[8]) begin
            r8_yq   <= r7_yq0 + 14'(n8_cy);
            r8_g    <= n8_ryc[10:2];
            r8_min  <= r7_min;
            r8_sec  <= r7_sec;
            r8_wd   <= r7_wd;
            r8_hour <= r7_hour;
            r8_greg <= r7_greg;
            r8_oos  <= r7_oos;
        end
        if (en[9]) begin
            r9_yq   <= r8_yq;
            r9_hq   <= n9_pq[14:11] + 4'(n9_c);
            r9_hr   <= n9_c ? 8'(n9_rh - 11'd153) : n9_rh[7:0];
            r9_min  <= r8_min;
            r9_sec  <= r8_sec;
            r9_wd   <= r8_wd;
            r9_hour <= r8_hour;
            r9_greg <= r8_greg;
            r9_oos  <= r8_oos;
        end
        if (en[10]) begin
            r10_res <= n10_res;
        end
    end

endmodule
